>>> rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, codes and constants for the SPI-mode SD card read controller.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SECTOR_SHIFT = 9;
  localparam int unsigned DUMMY_BYTES  = 10;

  // configuration register indexes
  localparam logic [2:0] CFG_POWER_OFF_TICKS     = 3'd0;
  localparam logic [2:0] CFG_RETRY_DELAY_TICKS   = 3'd1;
  localparam logic [2:0] CFG_RESPONSE_POLL_LIMIT = 3'd2;
  localparam logic [2:0] CFG_TOKEN_POLL_LIMIT    = 3'd3;
  localparam logic [2:0] CFG_IDLE_RETRY_LIMIT    = 3'd4;
  localparam logic [2:0] CFG_COND_RETRY_LIMIT    = 3'd5;
  localparam logic [2:0] CFG_OP_COND_RETRY_LIMIT = 3'd6;

  localparam logic [16:0] RST_POWER_OFF_TICKS     = 17'd100000;
  localparam logic [13:0] RST_RETRY_DELAY_TICKS   = 14'd10000;
  localparam logic [7:0]  RST_RESPONSE_POLL_LIMIT = 8'd100;
  localparam logic [13:0] RST_TOKEN_POLL_LIMIT    = 14'd10000;
  localparam logic [7:0]  RST_IDLE_RETRY_LIMIT    = 8'd100;
  localparam logic [7:0]  RST_COND_RETRY_LIMIT    = 8'd100;
  localparam logic [9:0]  RST_OP_COND_RETRY_LIMIT = 10'd1000;

  // commands and fixed bytes
  localparam logic [5:0]  CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0]  CMD_SEND_COND   = 6'd8;
  localparam logic [5:0]  CMD_READ_SINGLE = 6'd17;
  localparam logic [5:0]  CMD_OP_COND     = 6'd41;
  localparam logic [5:0]  CMD_APP         = 6'd55;
  localparam logic [31:0] ARG_SEND_COND   = 32'h0000_01aa;
  localparam logic [31:0] ARG_HCS         = 32'h4000_0000;
  localparam logic [31:0] ARG_TEST_SECTOR = 32'd1;
  localparam logic [7:0]  BYTE_FILL       = 8'hff;
  localparam logic [7:0]  BYTE_TOKEN      = 8'hfe;
  localparam logic [7:0]  BYTE_R1_EXTRA   = 8'h1f;
  localparam logic [7:0]  BYTE_R1_IDLE    = 8'h01;
  localparam logic [7:0]  BYTE_R1_READY   = 8'h00;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_READ = 2'd1,
    OP_BYTE = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IDLE_FAIL = 3'd1,
    ST_COND_FAIL = 3'd2,
    ST_OPC_FAIL  = 3'd3,
    ST_BAD_RESP  = 3'd4,
    ST_TOKEN_TO  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PWR   = 4'd1,
    PH_DUMMY = 4'd2,
    PH_FRAME = 4'd3,
    PH_RESP  = 4'd4,
    PH_EXTRA = 4'd5,
    PH_DELAY = 4'd6,
    PH_TOKEN = 4'd7,
    PH_DATA  = 4'd8,
    PH_CRC   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] sector_number;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic       power_enable;
    logic       card_select;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
    logic [2:0] status;
  } rsp_t;

  // crc7 (x^7+x^3+1) of a 40-bit message holding a single one at bit pos;
  // the crc is linear, so the crc of a message is the xor of these weights
  function automatic logic [6:0] crc7_weight(input int pos);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = ((i == pos) ? 1'b1 : 1'b0) ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ 7'h09;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/sd_card_spi_read_controller_unit.sv
// A word is held in the input register until it fires; its result word, if it
// has one, is registered into the result register when the word fires.
// Throughput: one word per cycle, limited only by result back-pressure.
// Reset: rst (synchronous) empties both registers, returns to idle, standard
// capacity, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// sd_card_spi_read_controller_unit
// SPI-mode SD card master, read path: init sequence and single-block reads.
// ----------------------------------------------------------------------------
module sd_card_spi_read_controller_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sdspi_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sdspi_pkg::rsp_t   rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [16:0]       cfg_data
);
  import sdspi_pkg::*;

  localparam logic [9:0] DUMMY_COUNT = 10'(DUMMY_BYTES);
  localparam logic [9:0] SECTOR_CNT  = 10'(SECTOR_BYTES);
  localparam logic [9:0] SECTOR_LAST = 10'(SECTOR_BYTES - 1);
  localparam logic [9:0] CRC_BYTES   = 10'd2;

  // configuration
  logic [16:0] power_off_ticks;
  logic [13:0] retry_delay_ticks;
  logic [7:0]  response_poll_limit;
  logic [13:0] token_poll_limit;
  logic [7:0]  idle_retry_limit;
  logic [7:0]  cond_retry_limit;
  logic [9:0]  op_cond_retry_limit;

  // input and result registers
  logic req_full;
  req_t req_q;
  rsp_t rsp_q;
  logic rsp_full;

  // controller state
  phase_t      phase, phase_next;
  logic        high_capacity, high_capacity_next;
  logic [47:0] frame_shift, frame_shift_next;
  logic [2:0]  frame_count, frame_count_next;
  logic [13:0] poll_count, poll_count_next;
  logic [9:0]  attempt_count, attempt_count_next;
  logic [9:0]  byte_index, byte_index_next;
  logic [16:0] wait_count, wait_count_next;
  logic        after_init_read, after_init_read_next;

  // actions decoded for the word in the input register
  logic        emit;
  logic        snd;
  logic [7:0]  snd_byte;
  logic        fin;
  status_t     fin_status;
  logic        dat_v;
  logic        dat_last;
  logic        cmd_go;
  logic [5:0]  cmd_sel;
  logic [31:0] cmd_arg;
  logic        do_resp;

  logic        out_free;
  logic        fire;
  rsp_t        res;

  // effective limits, zero acts as one
  logic [16:0] pwr_lim;
  logic [13:0] dly_lim;
  logic [7:0]  rsp_lim;
  logic [13:0] tok_lim;
  logic [7:0]  idl_lim;
  logic [7:0]  cnd_lim;
  logic [9:0]  opc_lim;

  logic [2:0]  fc_inc;
  logic [13:0] poll_inc;
  logic [9:0]  att_inc;
  logic [9:0]  bi_inc;
  logic [16:0] wc_inc;
  logic [5:0]  cur_cmd;
  logic [7:0]  rx;
  logic [31:0] read_addr;

  // command frame with crc
  logic [39:0] cmd_head;
  logic [6:0]  crc_terms [40];
  logic [6:0]  cmd_crc;
  logic [47:0] cmd_frame;

  assign pwr_lim = (power_off_ticks == '0) ? 17'd1 : power_off_ticks;
  assign dly_lim = (retry_delay_ticks == '0) ? 14'd1 : retry_delay_ticks;
  assign rsp_lim = (response_poll_limit == '0) ? 8'd1 : response_poll_limit;
  assign tok_lim = (token_poll_limit == '0) ? 14'd1 : token_poll_limit;
  assign idl_lim = (idle_retry_limit == '0) ? 8'd1 : idle_retry_limit;
  assign cnd_lim = (cond_retry_limit == '0) ? 8'd1 : cond_retry_limit;
  assign opc_lim = (op_cond_retry_limit == '0) ? 10'd1 : op_cond_retry_limit;

  assign fc_inc   = frame_count + 3'd1;
  assign poll_inc = poll_count + 14'd1;
  assign att_inc  = attempt_count + 10'd1;
  assign bi_inc   = byte_index + 10'd1;
  assign wc_inc   = wait_count + 17'd1;
  assign cur_cmd  = frame_shift[45:40];
  assign rx       = req_q.rx_byte;
  assign read_addr = high_capacity ? req_q.sector_number
                                   : 32'(req_q.sector_number << SECTOR_SHIFT);

  assign cmd_head = {2'b01, cmd_sel, cmd_arg};

  for (genvar g = 0; g < 40; g++) begin : g_crc
    localparam logic [6:0] WEIGHT = crc7_weight(g);
    assign crc_terms[g] = cmd_head[g] ? WEIGHT : 7'd0;
  end

  always_comb begin
    cmd_crc = '0;
    for (int i = 0; i < 40; i++) begin
      cmd_crc = cmd_crc ^ crc_terms[i];
    end
  end

  assign cmd_frame        = {cmd_head, cmd_crc, 1'b1};
  assign frame_shift_next = cmd_go ? cmd_frame : frame_shift;

  // next state
  always_comb begin
    phase_next           = phase;
    high_capacity_next   = high_capacity;
    frame_count_next     = frame_count;
    poll_count_next      = poll_count;
    attempt_count_next   = attempt_count;
    byte_index_next      = byte_index;
    wait_count_next      = wait_count;
    after_init_read_next = after_init_read;
    emit       = 1'b0;
    snd        = 1'b0;
    snd_byte   = BYTE_FILL;
    fin        = 1'b0;
    fin_status = ST_OK;
    dat_v      = 1'b0;
    dat_last   = 1'b0;
    cmd_go     = 1'b0;
    cmd_sel    = CMD_GO_IDLE;
    cmd_arg    = '0;
    do_resp    = 1'b0;

    case (op_t'(req_q.operation))
      OP_INIT: begin
        if (phase == PH_IDLE) begin
          after_init_read_next = 1'b0;
          phase_next           = PH_PWR;
          wait_count_next      = '0;
          emit                 = 1'b1;
        end
      end
      OP_READ: begin
        if (phase == PH_IDLE) begin
          after_init_read_next = 1'b0;
          cmd_go  = 1'b1;
          cmd_sel = CMD_READ_SINGLE;
          cmd_arg = read_addr;
        end
      end
      OP_BYTE: begin
        case (phase)
          PH_DUMMY: begin
            byte_index_next = bi_inc;
            if (bi_inc < DUMMY_COUNT) begin
              snd = 1'b1;
            end else begin
              attempt_count_next = 10'd1;
              cmd_go  = 1'b1;
              cmd_sel = CMD_GO_IDLE;
            end
          end
          PH_FRAME: begin
            frame_count_next = fc_inc;
            snd = 1'b1;
            case (fc_inc)
              3'd1:    snd_byte = frame_shift[47:40];
              3'd2:    snd_byte = frame_shift[39:32];
              3'd3:    snd_byte = frame_shift[31:24];
              3'd4:    snd_byte = frame_shift[23:16];
              3'd5:    snd_byte = frame_shift[15:8];
              3'd6:    snd_byte = frame_shift[7:0];
              default: begin
                phase_next      = PH_RESP;
                poll_count_next = '0;
              end
            endcase
          end
          PH_RESP: begin
            poll_count_next = poll_inc;
            if (rx[7] && (poll_inc < {6'd0, rsp_lim})) begin
              snd = 1'b1;
            end else if (rx == BYTE_R1_EXTRA) begin
              phase_next = PH_EXTRA;
              snd        = 1'b1;
            end else begin
              do_resp = 1'b1;
            end
          end
          PH_EXTRA: begin
            do_resp = 1'b1;
          end
          PH_TOKEN: begin
            poll_count_next = poll_inc;
            if (rx == BYTE_TOKEN) begin
              phase_next      = PH_DATA;
              byte_index_next = '0;
              snd             = 1'b1;
            end else if (poll_inc < tok_lim) begin
              snd = 1'b1;
            end else begin
              fin        = 1'b1;
              fin_status = ST_TOKEN_TO;
            end
          end
          PH_DATA: begin
            dat_v    = !after_init_read;
            dat_last = (byte_index == SECTOR_LAST);
            byte_index_next = bi_inc;
            if (bi_inc >= SECTOR_CNT) begin
              phase_next      = PH_CRC;
              byte_index_next = '0;
            end
            snd = 1'b1;
          end
          PH_CRC: begin
            byte_index_next = bi_inc;
            if (bi_inc < CRC_BYTES) begin
              snd = 1'b1;
            end else begin
              fin        = 1'b1;
              fin_status = ST_OK;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (phase == PH_PWR) begin
          wait_count_next = wc_inc;
          if (wc_inc >= pwr_lim) begin
            phase_next      = PH_DUMMY;
            byte_index_next = '0;
            snd             = 1'b1;
          end
        end else if (phase == PH_DELAY) begin
          wait_count_next = wc_inc;
          if (wc_inc >= {3'd0, dly_lim}) begin
            attempt_count_next = att_inc;
            cmd_go = 1'b1;
            if (cur_cmd == CMD_SEND_COND) begin
              cmd_sel = CMD_SEND_COND;
              cmd_arg = ARG_SEND_COND;
            end else begin
              cmd_sel = CMD_APP;
            end
          end
        end
      end
      default: ;
    endcase

    // command response handling
    if (do_resp) begin
      case (cur_cmd)
        CMD_GO_IDLE: begin
          if (rx == BYTE_R1_IDLE) begin
            attempt_count_next = 10'd1;
            cmd_go  = 1'b1;
            cmd_sel = CMD_SEND_COND;
            cmd_arg = ARG_SEND_COND;
          end else if (attempt_count < {2'd0, idl_lim}) begin
            attempt_count_next = att_inc;
            cmd_go  = 1'b1;
            cmd_sel = CMD_GO_IDLE;
          end else begin
            fin        = 1'b1;
            fin_status = ST_IDLE_FAIL;
          end
        end
        CMD_SEND_COND: begin
          if (rx == BYTE_R1_IDLE) begin
            attempt_count_next = 10'd1;
            cmd_go  = 1'b1;
            cmd_sel = CMD_APP;
          end else if (attempt_count < {2'd0, cnd_lim}) begin
            phase_next      = PH_DELAY;
            wait_count_next = '0;
            emit            = 1'b1;
          end else begin
            fin        = 1'b1;
            fin_status = ST_COND_FAIL;
          end
        end
        CMD_APP: begin
          cmd_go  = 1'b1;
          cmd_sel = CMD_OP_COND;
          cmd_arg = ARG_HCS;
        end
        CMD_OP_COND: begin
          if (rx == BYTE_R1_READY) begin
            high_capacity_next   = 1'b1;
            after_init_read_next = 1'b1;
            cmd_go  = 1'b1;
            cmd_sel = CMD_READ_SINGLE;
            cmd_arg = ARG_TEST_SECTOR;
          end else if (attempt_count < opc_lim) begin
            phase_next      = PH_DELAY;
            wait_count_next = '0;
            emit            = 1'b1;
          end else begin
            fin        = 1'b1;
            fin_status = ST_OPC_FAIL;
          end
        end
        default: begin
          if (rx == BYTE_R1_READY) begin
            phase_next      = PH_TOKEN;
            poll_count_next = '0;
            snd             = 1'b1;
          end else begin
            fin        = 1'b1;
            fin_status = ST_BAD_RESP;
          end
        end
      endcase
    end

    if (cmd_go) begin
      phase_next       = PH_FRAME;
      frame_count_next = '0;
      snd              = 1'b1;
      snd_byte         = BYTE_FILL;
    end
    if (fin) begin
      phase_next           = PH_IDLE;
      after_init_read_next = 1'b0;
    end
    emit = emit | snd | fin;
  end

  // result word
  always_comb begin
    res.power_enable = (phase_next != PH_PWR);
    case (phase_next)
      PH_FRAME, PH_RESP, PH_EXTRA, PH_TOKEN, PH_DATA, PH_CRC: res.card_select = 1'b1;
      default:                                              res.card_select = 1'b0;
    endcase
    res.tx_valid   = snd;
    res.tx_byte    = snd ? snd_byte : 8'd0;
    res.data_valid = dat_v;
    res.data_byte  = dat_v ? rx : 8'd0;
    res.data_last  = dat_v & dat_last;
    res.done_res   = fin;
    res.status     = fin ? fin_status : ST_OK;
  end

  // handshake
  assign out_free  = !rsp_full || rsp_ready;
  assign fire      = req_full && (!emit || out_free);
  assign req_ready = !req_full || fire;
  assign rsp_valid = rsp_full;
  assign rsp       = rsp_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && req_ready) begin
      req_full <= 1'b1;
    end else if (fire) begin
      req_full <= 1'b0;
    end
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (fire && emit) begin
      rsp_full <= 1'b1;
    end else if (rsp_ready) begin
      rsp_full <= 1'b0;
    end
    if (fire && emit) begin
      rsp_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      high_capacity   <= 1'b0;
      frame_shift     <= '0;
      frame_count     <= '0;
      poll_count      <= '0;
      attempt_count   <= '0;
      byte_index      <= '0;
      wait_count      <= '0;
      after_init_read <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      high_capacity   <= high_capacity_next;
      frame_shift     <= frame_shift_next;
      frame_count     <= frame_count_next;
      poll_count      <= poll_count_next;
      attempt_count   <= attempt_count_next;
      byte_index      <= byte_index_next;
      wait_count      <= wait_count_next;
      after_init_read <= after_init_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_off_ticks     <= RST_POWER_OFF_TICKS;
      retry_delay_ticks   <= RST_RETRY_DELAY_TICKS;
      response_poll_limit <= RST_RESPONSE_POLL_LIMIT;
      token_poll_limit    <= RST_TOKEN_POLL_LIMIT;
      idle_retry_limit    <= RST_IDLE_RETRY_LIMIT;
      cond_retry_limit    <= RST_COND_RETRY_LIMIT;
      op_cond_retry_limit <= RST_OP_COND_RETRY_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POWER_OFF_TICKS:     power_off_ticks     <= cfg_data;
        CFG_RETRY_DELAY_TICKS:   retry_delay_ticks   <= cfg_data[13:0];
        CFG_RESPONSE_POLL_LIMIT: response_poll_limit <= cfg_data[7:0];
        CFG_TOKEN_POLL_LIMIT:    token_poll_limit    <= cfg_data[13:0];
        CFG_IDLE_RETRY_LIMIT:    idle_retry_limit    <= cfg_data[7:0];
        CFG_COND_RETRY_LIMIT:    cond_retry_limit    <= cfg_data[7:0];
        CFG_OP_COND_RETRY_LIMIT: op_cond_retry_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sd_card_spi_read_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_card_spi_read_controller_unit_tb
// Drives init, read, received-byte and tick words into the SD card read
// controller and checks each result word against a cycle-free model of the
// card master kept in this file. The stimulus is steered by a second copy of
// that model, so init sequences and reads get answered with plausible card
// responses while random content, noise and broken responses mix in.
// ----------------------------------------------------------------------------
module sd_card_spi_read_controller_unit_tb;
  import sdspi_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [16:0] pwr_off;
    logic [13:0] retry_gap;
    logic [7:0]  resp_polls;
    logic [13:0] token_polls;
    logic [7:0]  idle_tries;
    logic [7:0]  cond_tries;
    logic [9:0]  opc_tries;
  } reg_set_t;

  typedef struct packed {
    phase_t      ph;
    logic        hc;
    logic [47:0] frame;
    logic [2:0]  fcnt;
    logic [13:0] polls;
    logic [9:0]  tries;
    logic [9:0]  bidx;
    logic [16:0] ticks;
    logic        test_read;
  } card_state_t;

  typedef struct packed {
    logic hit;
    rsp_t w;
  } step_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  req_t        stim_q[$];
  rsp_t        want_q[$];
  card_state_t plan_st;
  card_state_t chk_st;
  reg_set_t    cfg_now;
  int unsigned offered_n = 0;
  int unsigned accepted_n = 0;
  int unsigned fail_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;

  sd_card_spi_read_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- card model

  function automatic int unsigned floor_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic card_state_t idle_card();
    card_state_t s;
    s = '0;
    s.ph = PH_IDLE;
    return s;
  endfunction

  function automatic reg_set_t default_regs();
    reg_set_t c;
    c.pwr_off     = RST_POWER_OFF_TICKS;
    c.retry_gap   = RST_RETRY_DELAY_TICKS;
    c.resp_polls  = RST_RESPONSE_POLL_LIMIT;
    c.token_polls = RST_TOKEN_POLL_LIMIT;
    c.idle_tries  = RST_IDLE_RETRY_LIMIT;
    c.cond_tries  = RST_COND_RETRY_LIMIT;
    c.opc_tries   = RST_OP_COND_RETRY_LIMIT;
    return c;
  endfunction

  // serial crc7, polynomial x^7+x^3+1, over command byte and argument
  function automatic logic [6:0] frame_crc7(input logic [39:0] msg);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = msg[i] ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ 7'h09;
      end
    end
    return crc;
  endfunction

  function automatic logic [5:0] frame_cmd(input card_state_t s);
    return s.frame[45:40];
  endfunction

  function automatic logic on_bus(input phase_t p);
    return p == PH_FRAME || p == PH_RESP || p == PH_EXTRA || p == PH_TOKEN ||
           p == PH_DATA || p == PH_CRC;
  endfunction

  function automatic void send_byte(inout step_out_t y, input logic [7:0] b);
    y.hit        = 1'b1;
    y.w.tx_valid = 1'b1;
    y.w.tx_byte  = b;
  endfunction

  function automatic void end_op(inout card_state_t s, inout step_out_t y,
                                 input status_t st);
    s.ph         = PH_IDLE;
    s.test_read  = 1'b0;
    y.hit        = 1'b1;
    y.w.done_res = 1'b1;
    y.w.status   = st;
  endfunction

  function automatic void issue_cmd(inout card_state_t s, inout step_out_t y,
                                    input logic [5:0] cmd, input logic [31:0] arg);
    logic [39:0] head;
    head    = {2'b01, cmd, arg};
    s.frame = {head, frame_crc7(head), 1'b1};
    s.fcnt  = '0;
    s.ph    = PH_FRAME;
    send_byte(y, BYTE_FILL);
  endfunction

  function automatic void retry_wait(inout card_state_t s, inout step_out_t y);
    s.ph    = PH_DELAY;
    s.ticks = '0;
    y.hit   = 1'b1;
  endfunction

  function automatic void take_response(inout card_state_t s, inout step_out_t y,
                                        input reg_set_t c, input logic [7:0] r);
    case (frame_cmd(s))
      CMD_GO_IDLE: begin
        if (r == BYTE_R1_IDLE) begin
          s.tries = 10'd1;
          issue_cmd(s, y, CMD_SEND_COND, ARG_SEND_COND);
        end else if (s.tries < floor_one(c.idle_tries)) begin
          s.tries = s.tries + 10'd1;
          issue_cmd(s, y, CMD_GO_IDLE, 32'h0);
        end else begin
          end_op(s, y, ST_IDLE_FAIL);
        end
      end
      CMD_SEND_COND: begin
        if (r == BYTE_R1_IDLE) begin
          s.tries = 10'd1;
          issue_cmd(s, y, CMD_APP, 32'h0);
        end else if (s.tries < floor_one(c.cond_tries)) begin
          retry_wait(s, y);
        end else begin
          end_op(s, y, ST_COND_FAIL);
        end
      end
      CMD_APP: begin
        // the app-command response does not matter
        issue_cmd(s, y, CMD_OP_COND, ARG_HCS);
      end
      CMD_OP_COND: begin
        if (r == BYTE_R1_READY) begin
          s.hc        = 1'b1;
          s.test_read = 1'b1;
          issue_cmd(s, y, CMD_READ_SINGLE, ARG_TEST_SECTOR);
        end else if (s.tries < floor_one(c.opc_tries)) begin
          retry_wait(s, y);
        end else begin
          end_op(s, y, ST_OPC_FAIL);
        end
      end
      default: begin
        if (r == BYTE_R1_READY) begin
          s.ph    = PH_TOKEN;
          s.polls = '0;
          send_byte(y, BYTE_FILL);
        end else begin
          end_op(s, y, ST_BAD_RESP);
        end
      end
    endcase
  endfunction

  // advances the card master by one input word, returns the result word if any
  function automatic step_out_t card_step(inout card_state_t s, input reg_set_t c,
                                          input req_t r);
    step_out_t y;
    y = '0;
    case (op_t'(r.operation))
      OP_INIT: begin
        if (s.ph == PH_IDLE) begin
          s.test_read = 1'b0;
          s.ph        = PH_PWR;
          s.ticks     = '0;
          y.hit       = 1'b1;
        end
      end
      OP_READ: begin
        if (s.ph == PH_IDLE) begin
          s.test_read = 1'b0;
          // byte addressing wraps at 32 bits for standard capacity cards
          issue_cmd(s, y, CMD_READ_SINGLE,
                    s.hc ? r.sector_number : (r.sector_number << SECTOR_SHIFT));
        end
      end
      OP_BYTE: begin
        case (s.ph)
          PH_DUMMY: begin
            s.bidx = s.bidx + 10'd1;
            if (s.bidx < DUMMY_BYTES) begin
              send_byte(y, BYTE_FILL);
            end else begin
              s.tries = 10'd1;
              issue_cmd(s, y, CMD_GO_IDLE, 32'h0);
            end
          end
          PH_FRAME: begin
            s.fcnt = s.fcnt + 3'd1;
            if (s.fcnt <= 3'd6) begin
              send_byte(y, s.frame[8 * (6 - s.fcnt) +: 8]);
            end else begin
              s.ph    = PH_RESP;
              s.polls = '0;
              send_byte(y, BYTE_FILL);
            end
          end
          PH_RESP: begin
            s.polls = s.polls + 14'd1;
            if (r.rx_byte[7] && s.polls < floor_one(c.resp_polls)) begin
              send_byte(y, BYTE_FILL);
            end else if (r.rx_byte == BYTE_R1_EXTRA) begin
              s.ph = PH_EXTRA;
              send_byte(y, BYTE_FILL);
            end else begin
              take_response(s, y, c, r.rx_byte);
            end
          end
          PH_EXTRA: begin
            take_response(s, y, c, r.rx_byte);
          end
          PH_TOKEN: begin
            s.polls = s.polls + 14'd1;
            if (r.rx_byte == BYTE_TOKEN) begin
              s.ph   = PH_DATA;
              s.bidx = '0;
              send_byte(y, BYTE_FILL);
            end else if (s.polls < floor_one(c.token_polls)) begin
              send_byte(y, BYTE_FILL);
            end else begin
              end_op(s, y, ST_TOKEN_TO);
            end
          end
          PH_DATA: begin
            // test read data after init stays inside the block
            if (!s.test_read) begin
              y.w.data_valid = 1'b1;
              y.w.data_byte  = r.rx_byte;
              y.w.data_last  = (s.bidx == SECTOR_BYTES - 1);
            end
            s.bidx = s.bidx + 10'd1;
            if (s.bidx >= SECTOR_BYTES) begin
              s.ph   = PH_CRC;
              s.bidx = '0;
            end
            send_byte(y, BYTE_FILL);
          end
          PH_CRC: begin
            s.bidx = s.bidx + 10'd1;
            if (s.bidx < 2) begin
              send_byte(y, BYTE_FILL);
            end else begin
              end_op(s, y, ST_OK);
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (s.ph == PH_PWR) begin
          s.ticks = s.ticks + 17'd1;
          if (s.ticks >= floor_one(c.pwr_off)) begin
            s.ph   = PH_DUMMY;
            s.bidx = '0;
            send_byte(y, BYTE_FILL);
          end
        end else if (s.ph == PH_DELAY) begin
          s.ticks = s.ticks + 17'd1;
          if (s.ticks >= floor_one(c.retry_gap)) begin
            s.tries = s.tries + 10'd1;
            if (frame_cmd(s) == CMD_SEND_COND) begin
              issue_cmd(s, y, CMD_SEND_COND, ARG_SEND_COND);
            end else begin
              issue_cmd(s, y, CMD_APP, 32'h0);
            end
          end
        end
      end
    endcase
    if (y.hit) begin
      y.w.power_enable = (s.ph != PH_PWR);
      y.w.card_select  = on_bus(s.ph);
    end
    return y;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic offer(input op_t op, input logic [31:0] sec, input logic [7:0] rx);
    req_t it;
    it.operation     = op;
    it.sector_number = sec;
    it.rx_byte       = rx;
    void'(card_step(plan_st, cfg_now, it));
    stim_q.push_back(it);
    offered_n++;
  endtask

  function automatic logic [31:0] rand_sector();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] good_response(input logic [5:0] cmd);
    if (cmd == CMD_GO_IDLE || cmd == CMD_SEND_COND || cmd == CMD_APP) begin
      return BYTE_R1_IDLE;
    end
    return BYTE_R1_READY;
  endfunction

  function automatic logic [7:0] pick_response(input logic [5:0] cmd);
    int unsigned d;
    d = $urandom_range(99);
    if (d < 60) return good_response(cmd);
    if (d < 70) return BYTE_R1_EXTRA;
    if (d < 85) return {1'b1, 7'($urandom)};
    return 8'($urandom);
  endfunction

  // feed bytes while the block only clocks out fill bytes or a frame
  task automatic pump();
    while (plan_st.ph == PH_DUMMY || plan_st.ph == PH_FRAME) begin
      offer(OP_BYTE, $urandom, 8'($urandom));
    end
  endtask

  // answer like a healthy card until the operation ends; quick makes reads fail
  task automatic settle(input bit quick);
    logic [5:0] cmd;
    while (plan_st.ph != PH_IDLE) begin
      cmd = frame_cmd(plan_st);
      case (plan_st.ph)
        PH_PWR, PH_DELAY: offer(OP_TICK, $urandom, 8'($urandom));
        PH_RESP, PH_EXTRA: begin
          if (quick && cmd == CMD_READ_SINGLE) begin
            offer(OP_BYTE, $urandom, 8'h04);
          end else begin
            offer(OP_BYTE, $urandom, good_response(cmd));
          end
        end
        PH_TOKEN: offer(OP_BYTE, $urandom, quick ? 8'h00 : BYTE_TOKEN);
        default: offer(OP_BYTE, $urandom, 8'($urandom));
      endcase
    end
  endtask

  task automatic random_run(input int unsigned n);
    int unsigned done_n;
    int unsigned dice;
    logic [7:0]  rx;
    done_n = 0;
    while (done_n < n) begin
      dice = $urandom_range(99);
      rx   = 8'($urandom);
      if (dice < 6) begin
        // noise: any word regardless of what the block waits for
        offer(op_t'($urandom_range(3)), $urandom, rx);
      end else begin
        done_n++;
        case (plan_st.ph)
          PH_IDLE: begin
            if (dice < 45) begin
              offer(OP_INIT, $urandom, rx);
            end else begin
              offer(OP_READ, rand_sector(), rx);
            end
          end
          PH_PWR, PH_DELAY: offer(OP_TICK, $urandom, rx);
          PH_RESP: offer(OP_BYTE, $urandom, pick_response(frame_cmd(plan_st)));
          PH_EXTRA: begin
            if ($urandom_range(9) < 7) begin
              offer(OP_BYTE, $urandom, good_response(frame_cmd(plan_st)));
            end else begin
              offer(OP_BYTE, $urandom, rx);
            end
          end
          PH_TOKEN: offer(OP_BYTE, $urandom, ($urandom_range(9) < 4) ? BYTE_TOKEN : rx);
          default: offer(OP_BYTE, $urandom, rx);
        endcase
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POWER_OFF_TICKS:     cfg_now.pwr_off     = val;
      CFG_RETRY_DELAY_TICKS:   cfg_now.retry_gap   = val[13:0];
      CFG_RESPONSE_POLL_LIMIT: cfg_now.resp_polls  = val[7:0];
      CFG_TOKEN_POLL_LIMIT:    cfg_now.token_polls = val[13:0];
      CFG_IDLE_RETRY_LIMIT:    cfg_now.idle_tries  = val[7:0];
      CFG_COND_RETRY_LIMIT:    cfg_now.cond_tries  = val[7:0];
      CFG_OP_COND_RETRY_LIMIT: cfg_now.opc_tries   = val[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (accepted_n != offered_n || want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    plan_st      = idle_card();
    chk_st       = idle_card();
    cfg_now      = default_regs();
    send_gap_pct = 21;
    recv_gap_pct = 53;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short delays and limits; junk above each register's width gets dropped
    write_reg(CFG_POWER_OFF_TICKS, 17'($urandom_range(20)));
    write_reg(CFG_RETRY_DELAY_TICKS, {3'($urandom), 14'($urandom_range(10))});
    write_reg(CFG_RESPONSE_POLL_LIMIT, {9'($urandom), 8'($urandom_range(1, 6))});
    write_reg(CFG_TOKEN_POLL_LIMIT, {3'($urandom), 14'($urandom_range(1, 8))});
    write_reg(CFG_IDLE_RETRY_LIMIT, {9'($urandom), 8'($urandom_range(1, 4))});
    write_reg(CFG_COND_RETRY_LIMIT, {9'($urandom), 8'($urandom_range(1, 3))});
    write_reg(CFG_OP_COND_RETRY_LIMIT, {7'($urandom), 10'($urandom_range(1, 4))});

    // stray byte and tick while idle
    offer(OP_BYTE, 32'h0, 8'h00);
    offer(OP_TICK, 32'hffff_ffff, 8'hff);
    // top sector before init: byte address wraps; requests while busy are dropped
    offer(OP_READ, 32'hffff_ffff, 8'h00);
    offer(OP_READ, 32'h0, 8'hff);
    offer(OP_INIT, 32'h0, 8'h00);
    pump();
    offer(OP_BYTE, 32'h0, 8'hff);
    offer(OP_BYTE, 32'h0, BYTE_R1_EXTRA);
    offer(OP_BYTE, 32'h0, BYTE_R1_READY);
    offer(OP_BYTE, 32'h0, 8'h00);
    settle(1'b1);
    // extra byte after 0x1f is taken as the response itself
    offer(OP_READ, 32'h0, 8'h00);
    pump();
    offer(OP_BYTE, 32'h0, BYTE_R1_EXTRA);
    offer(OP_BYTE, 32'h0, 8'hff);
    settle(1'b1);
    offer(OP_INIT, 32'h0, 8'h00);
    settle(1'b1);

    random_run(250);
    hold_go <= 1'b1;
    settle(1'b1);
    wait_drained();

    // zero settings: one tick, one poll, one try
    send_gap_pct = 53;
    recv_gap_pct = 21;
    write_reg(CFG_POWER_OFF_TICKS, 17'h0);
    write_reg(CFG_RETRY_DELAY_TICKS, 17'h0);
    write_reg(CFG_RESPONSE_POLL_LIMIT, 17'h0);
    write_reg(CFG_TOKEN_POLL_LIMIT, 17'h0);
    write_reg(CFG_IDLE_RETRY_LIMIT, 17'h0);
    write_reg(CFG_COND_RETRY_LIMIT, 17'h0);
    write_reg(CFG_OP_COND_RETRY_LIMIT, 17'h0);
    random_run(100);
    wait_drained();
    random_run(100);
    settle(1'b1);
    wait_drained();

    // full-scale limits with a short power-off, an init and a read
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_reg(CFG_POWER_OFF_TICKS, 17'd40);
    write_reg(CFG_RETRY_DELAY_TICKS, 17'h3fff);
    write_reg(CFG_RESPONSE_POLL_LIMIT, 17'hff);
    write_reg(CFG_TOKEN_POLL_LIMIT, 17'h3fff);
    write_reg(CFG_IDLE_RETRY_LIMIT, 17'hff);
    write_reg(CFG_COND_RETRY_LIMIT, 17'hff);
    write_reg(CFG_OP_COND_RETRY_LIMIT, 17'h3ff);
    offer(OP_INIT, $urandom, 8'($urandom));
    settle(1'b1);
    offer(OP_READ, 32'hffff_ffff, 8'($urandom));
    settle(1'b1);
    wait_drained();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : feed
    step_out_t y;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        accepted_n++;
        y = card_step(chk_st, cfg_now, req);
        if (y.hit) begin
          want_q.push_back(y.w);
        end
      end
      if (!req_valid || req_ready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_valid <= 1'b1;
          req       <= stim_q.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void match_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_word(input rsp_t got);
    rsp_t want;
    if (want_q.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      fail_count++;
    end else begin
      want = want_q.pop_front();
      match_field("power_enable", want.power_enable, got.power_enable);
      match_field("card_select", want.card_select, got.card_select);
      match_field("tx_valid", want.tx_valid, got.tx_valid);
      match_field("tx_byte", want.tx_byte, got.tx_byte);
      match_field("data_valid", want.data_valid, got.data_valid);
      match_field("data_byte", want.data_byte, got.data_byte);
      match_field("data_last", want.data_last, got.data_last);
      match_field("done_res", want.done_res, got.done_res);
      match_field("status", want.status, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        check_word(rsp);
      end
      // one long hold-off so the block backs up into its input
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/sdspi_pkg.sv
rtl/sd_card_spi_read_controller_unit.sv
tb/sd_card_spi_read_controller_unit_tb.sv
